/* design/bitmap_glyph_row_renderer_defines.svh */
// ---------------------------------------------------------------------------
// Glyph row renderer assertion macros
// Concurrent assertion helpers used by the renderer top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_ROW_RENDERER_DEFINES_SVH
`define BITMAP_GLYPH_ROW_RENDERER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define BGR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication.
`define BGR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define BGR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BGR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* design/bgr_pkg.sv */
// ---------------------------------------------------------------------------
// Glyph row renderer package
// Shared constants, register map, configuration struct and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package bgr_pkg;

   localparam int MAX_GLYPH_ROWS  = 16;
   localparam int CHAR_CODES      = 256;
   localparam int COORD_BITS      = 16;
   localparam int STORE_DEPTH     = CHAR_CODES * MAX_GLYPH_ROWS;
   localparam int STORE_ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int ROW_BITS        = $clog2(MAX_GLYPH_ROWS);
   localparam int WIDTH_BITS      = 4;
   localparam int HEIGHT_BITS     = 5;
   localparam int CODE_BITS       = 8;
   localparam int GLYPH_COLS      = 8;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;
   localparam int REQ_DATA_BITS   = 32;
   localparam int RSP_DATA_BITS   = 40;

   localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CODE_BITS-1:0] TERM_CODE    = 8'd0;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic [2:0] REG_CLIP_LEFT    = 3'd0;
   localparam logic [2:0] REG_CLIP_TOP     = 3'd1;
   localparam logic [2:0] REG_CLIP_RIGHT   = 3'd2;
   localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd3;
   localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd4;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd5;

   typedef struct packed {
      logic [COORD_BITS-1:0]  clip_left;
      logic [COORD_BITS-1:0]  clip_top;
      logic [COORD_BITS-1:0]  clip_right;
      logic [COORD_BITS-1:0]  clip_bottom;
      logic [WIDTH_BITS-1:0]  width_eff;
      logic [HEIGHT_BITS-1:0] height_eff;
   } cfg_type;

   // Clamp a coordinate sum to the largest coordinate.
   function automatic logic [COORD_BITS-1:0] coord_sat(input logic [COORD_BITS:0] sum);
      coord_sat = sum[COORD_BITS] ? {COORD_BITS{1'b1}} : sum[COORD_BITS-1:0];
   endfunction

   function automatic logic [WIDTH_BITS-1:0] width_clamp(input logic [WIDTH_BITS-1:0] w);
      if (w == '0) begin
         width_clamp = WIDTH_BITS'(1);
      end else if (w > WIDTH_BITS'(GLYPH_COLS)) begin
         width_clamp = WIDTH_BITS'(GLYPH_COLS);
      end else begin
         width_clamp = w;
      end
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] height_clamp(input logic [HEIGHT_BITS-1:0] h);
      if (h == '0) begin
         height_clamp = HEIGHT_BITS'(1);
      end else if (h > HEIGHT_BITS'(MAX_GLYPH_ROWS)) begin
         height_clamp = HEIGHT_BITS'(MAX_GLYPH_ROWS);
      end else begin
         height_clamp = h;
      end
   endfunction

endpackage

`default_nettype wire

/* design/bitmap_glyph_row_renderer.sv */
// Flow: load, newline and terminator items leave the block idle; a character is registered
//    on acceptance, its rows are read in turn into the glyph store read register and moved
//    to the output register. Throughput: one row item per cycle while the output is taken,
//    one store read per row; new items wait until the last row reaches the output register.
// Reset: synchronous, active high; cursor at zero, registers at their defaults, glyph
//    store contents undefined until loaded.
// ---------------------------------------------------------------------------
// Bitmap glyph row renderer
// Renders text characters from a glyph store into per-row column masks.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitmap_glyph_row_renderer_defines.svh"

module bitmap_glyph_row_renderer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: glyph_address[11:0], glyph_byte[19:12], char_code[27:20],
   //        first_of_string[28], zero fill[31:29]
   input  wire logic [bgr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: mode[0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: row_y[15:0], row_x[31:16], column_mask[39:32]
   output logic      [bgr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bgr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [bgr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [bgr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_ROWS = 2'b10
   } state_type;

   localparam int CB = bgr_pkg::COORD_BITS;
   localparam int AB = bgr_pkg::STORE_ADDR_BITS;
   localparam int RB = bgr_pkg::ROW_BITS;
   localparam int HB = bgr_pkg::HEIGHT_BITS;
   localparam int WB = bgr_pkg::WIDTH_BITS;
   localparam int NC = bgr_pkg::GLYPH_COLS;

   bgr_pkg::cfg_type cfg;

   state_type         state_ff, state_in;
   logic [CB-1:0]     cursor_x_ff, cursor_x_in;
   logic [CB-1:0]     cursor_y_ff, cursor_y_in;
   logic [CB-1:0]     item_x_ff, item_x_in;
   logic [CB-1:0]     item_y_ff, item_y_in;
   logic [AB-1:0]     base_ff, base_in;
   logic [WB-1:0]     width_ff, width_in;
   logic [HB-1:0]     height_ff, height_in;
   logic [RB-1:0]     iss_row_ff, iss_row_in;
   logic              iss_done_ff, iss_done_in;
   logic              pend_ff, pend_in;
   logic [RB-1:0]     pend_row_ff, pend_row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff;
   logic [bgr_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   logic                          req_acc;
   logic [AB-1:0]                 in_addr;
   logic [7:0]                    in_byte;
   logic [bgr_pkg::CODE_BITS-1:0] in_code;
   logic                          in_first;
   logic [CB-1:0]                 cur_x;
   logic [CB-1:0]                 cur_y;
   logic                          ram_wr_en;
   logic                          rd_en;
   logic [AB-1:0]                 rd_addr;
   logic [7:0]                    rd_line;
   logic                          out_free;
   logic                          load_out;
   logic                          iss_last;
   logic                          pend_last;
   logic [CB:0]                   y_unsat;
   logic [NC-1:0]                 mask;

   bgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Loads are taken only when idle and reads only while rendering, so the
   // two ports never touch the same entry in the same cycle.
   bgr_glyph_ram #(
      .DATA_BITS (8),
      .DEPTH     (bgr_pkg::STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (in_addr),
      .wr_data (in_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_line)
   );

   assign in_addr  = req_tdata[11:0];
   assign in_byte  = req_tdata[19:12];
   assign in_code  = req_tdata[27:20];
   assign in_first = req_tdata[28];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ram_wr_en  = req_acc && (req_tuser == bgr_pkg::MODE_LOAD);

   assign cur_x = in_first ? cfg.clip_left : cursor_x_ff;
   assign cur_y = in_first ? cfg.clip_top  : cursor_y_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load_out  = pend_ff && out_free;
   assign rd_en     = (state_ff == ST_ROWS) && !iss_done_ff && (!pend_ff || out_free);
   assign rd_addr   = base_ff + AB'(iss_row_ff);
   assign iss_last  = ({1'b0, iss_row_ff} + HB'(1)) == height_ff;
   assign pend_last = ({1'b0, pend_row_ff} + HB'(1)) == height_ff;

   always_comb begin
      state_in    = state_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      item_x_in   = item_x_ff;
      item_y_in   = item_y_ff;
      base_in     = base_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      iss_row_in  = iss_row_ff;
      iss_done_in = iss_done_ff;
      pend_row_in = pend_row_ff;

      if (req_acc && (req_tuser == bgr_pkg::MODE_RENDER)) begin
         if (in_code == bgr_pkg::TERM_CODE) begin
            cursor_x_in = cur_x;
            cursor_y_in = cur_y;
         end else if (in_code == bgr_pkg::NEWLINE_CODE) begin
            cursor_x_in = cfg.clip_left;
            cursor_y_in = bgr_pkg::coord_sat({1'b0, cur_y} + (CB+1)'(cfg.height_eff));
         end else begin
            cursor_x_in = bgr_pkg::coord_sat({1'b0, cur_x} + (CB+1)'(cfg.width_eff));
            cursor_y_in = cur_y;
            item_x_in   = cur_x;
            item_y_in   = cur_y;
            base_in     = AB'(in_code * cfg.height_eff);
            width_in    = cfg.width_eff;
            height_in   = cfg.height_eff;
            iss_row_in  = '0;
            iss_done_in = 1'b0;
            state_in    = ST_ROWS;
         end
      end

      if (rd_en) begin
         iss_row_in  = iss_row_ff + RB'(1);
         iss_done_in = iss_last;
         pend_row_in = iss_row_ff;
      end

      if (rd_en) begin
         pend_in = 1'b1;
      end else if (load_out) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end

      if ((state_ff == ST_ROWS) && iss_done_ff && !pend_ff) begin
         state_in = ST_IDLE;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Column mask: glyph bit (width-1-j) drives column j, clipped to the rectangle.
   always_comb begin
      logic [WB-1:0] bit_pos;
      logic [CB:0]   x_unsat;
      logic          y_ok;
      y_unsat = {1'b0, item_y_ff} + (CB+1)'(pend_row_ff);
      y_ok    = y_unsat < {1'b0, cfg.clip_bottom};
      mask    = '0;
      for (int j = 0; j < NC; j++) begin
         bit_pos = width_ff - WB'(j) - WB'(1);
         x_unsat = {1'b0, item_x_ff} + (CB+1)'(j);
         if ((WB'(j) < width_ff) && rd_line[bit_pos[2:0]] && y_ok &&
             (x_unsat < {1'b0, cfg.clip_right})) begin
            mask[j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         iss_done_ff  <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         iss_done_ff  <= iss_done_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_x_ff   <= item_x_in;
      item_y_ff   <= item_y_in;
      base_ff     <= base_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      iss_row_ff  <= iss_row_in;
      pend_row_ff <= pend_row_in;
      if (load_out) begin
         rsp_data_ff <= {mask, item_x_ff, bgr_pkg::coord_sat(y_unsat)};
         rsp_last_ff <= pend_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BGR_ASSERT_IMP(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_ff)
   `BGR_ASSERT_IMP(a_read_no_overrun, clock, reset, rd_en, !pend_ff || out_free)
   `BGR_ASSERT_NXT(a_load_stays_idle, clock, reset,
      req_acc && (req_tuser == bgr_pkg::MODE_LOAD), state_ff == ST_IDLE)
   `BGR_ASSERT_IMP(a_last_after_issue, clock, reset, load_out && pend_last, iss_done_ff)

endmodule

`default_nettype wire

/* design/bgr_csr.sv */
// ---------------------------------------------------------------------------
// Glyph row renderer register block
// APB-style register file holding the clip rectangle and glyph size.
// ---------------------------------------------------------------------------
`default_nettype none

module bgr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bgr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [bgr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [bgr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready,
   output bgr_pkg::cfg_type                        cfg
);

   logic [bgr_pkg::COORD_BITS-1:0]  clip_left_ff, clip_left_in;
   logic [bgr_pkg::COORD_BITS-1:0]  clip_top_ff, clip_top_in;
   logic [bgr_pkg::COORD_BITS-1:0]  clip_right_ff, clip_right_in;
   logic [bgr_pkg::COORD_BITS-1:0]  clip_bottom_ff, clip_bottom_in;
   logic [bgr_pkg::WIDTH_BITS-1:0]  glyph_width_ff, glyph_width_in;
   logic [bgr_pkg::HEIGHT_BITS-1:0] glyph_height_ff, glyph_height_in;
   logic [2:0]                      reg_index;
   logic                            wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      clip_left_in    = clip_left_ff;
      clip_top_in     = clip_top_ff;
      clip_right_in   = clip_right_ff;
      clip_bottom_in  = clip_bottom_ff;
      glyph_width_in  = glyph_width_ff;
      glyph_height_in = glyph_height_ff;
      if (wr_en) begin
         case (reg_index)
            bgr_pkg::REG_CLIP_LEFT:    clip_left_in    = csr_pwdata[15:0];
            bgr_pkg::REG_CLIP_TOP:     clip_top_in     = csr_pwdata[15:0];
            bgr_pkg::REG_CLIP_RIGHT:   clip_right_in   = csr_pwdata[15:0];
            bgr_pkg::REG_CLIP_BOTTOM:  clip_bottom_in  = csr_pwdata[15:0];
            bgr_pkg::REG_GLYPH_WIDTH:  glyph_width_in  = csr_pwdata[3:0];
            bgr_pkg::REG_GLYPH_HEIGHT: glyph_height_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff    <= '0;
         clip_top_ff     <= '0;
         clip_right_ff   <= '1;
         clip_bottom_ff  <= '1;
         glyph_width_ff  <= bgr_pkg::WIDTH_BITS'(8);
         glyph_height_ff <= bgr_pkg::HEIGHT_BITS'(16);
      end else begin
         clip_left_ff    <= clip_left_in;
         clip_top_ff     <= clip_top_in;
         clip_right_ff   <= clip_right_in;
         clip_bottom_ff  <= clip_bottom_in;
         glyph_width_ff  <= glyph_width_in;
         glyph_height_ff <= glyph_height_in;
      end
   end

   always_comb begin
      case (reg_index)
         bgr_pkg::REG_CLIP_LEFT:    csr_prdata = 32'(clip_left_ff);
         bgr_pkg::REG_CLIP_TOP:     csr_prdata = 32'(clip_top_ff);
         bgr_pkg::REG_CLIP_RIGHT:   csr_prdata = 32'(clip_right_ff);
         bgr_pkg::REG_CLIP_BOTTOM:  csr_prdata = 32'(clip_bottom_ff);
         bgr_pkg::REG_GLYPH_WIDTH:  csr_prdata = 32'(glyph_width_ff);
         bgr_pkg::REG_GLYPH_HEIGHT: csr_prdata = 32'(glyph_height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.clip_left   = clip_left_ff;
   assign cfg.clip_top    = clip_top_ff;
   assign cfg.clip_right  = clip_right_ff;
   assign cfg.clip_bottom = clip_bottom_ff;
   assign cfg.width_eff   = bgr_pkg::width_clamp(glyph_width_ff);
   assign cfg.height_eff  = bgr_pkg::height_clamp(glyph_height_ff);

endmodule

`default_nettype wire

/* design/bgr_glyph_ram.sv */
// ---------------------------------------------------------------------------
// Glyph store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bgr_glyph_ram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
